// File: rtl/hslrgb_pkg.sv
package hslrgb_pkg;

   localparam int FIXED_SHIFT = 12;
   localparam int FIXED_ONE   = 1 << FIXED_SHIFT;
   localparam int FIXED_HALF  = FIXED_ONE / 2;
   localparam int HUE_SECTORS = 6;
   localparam int HUE_TURN    = HUE_SECTORS * FIXED_ONE;
   localparam int CLAMP_LIMIT = 'h100;
   localparam int CLAMP_MAX   = 'hFF;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [12:0] lightness;
      logic [12:0] saturation;
      logic [7:0]  scale;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // front -> span: first scaled extreme plus what the rest needs
   typedef struct packed {
      chan_type    top;
      chan_type    lo;
      chan_type    mid;
      logic        low;
      logic [31:0] first;
      logic [21:0] twice;
      logic [12:0] w;
   } span_in_type;

   // span -> out: both extremes and the interpolation product
   typedef struct packed {
      chan_type    top;
      chan_type    lo;
      chan_type    mid;
      logic [31:0] c_top;
      logic [31:0] c_lo;
      logic [31:0] prod;
   } tail_type;

   function automatic logic [2:0] sector_of(input logic [2:0] unit);
      logic [2:0] s;
      case (unit)
         3'd0: s = 3'd1;
         3'd1: s = 3'd2;
         3'd2: s = 3'd3;
         3'd3: s = 3'd4;
         3'd4: s = 3'd5;
         3'd5: s = 3'd0;
         3'd6: s = 3'd1;
         3'd7: s = 3'd2;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic chan_type next_chan(input chan_type c);
      chan_type n;
      case (c)
         CH_RED:   n = CH_GREEN;
         CH_GREEN: n = CH_BLUE;
         CH_BLUE:  n = CH_RED;
         default:  n = CH_RED;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/hslrgb_front.sv
module hslrgb_front import hslrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output span_in_type out_data
);

   typedef struct packed {
      chan_type           top;
      chan_type           lo;
      chan_type           mid;
      logic               low;
      logic signed [27:0] lprod;
      logic [12:0]        sat;
      logic [7:0]         k;
      logic [21:0]        twice;
      logic [12:0]        w;
   } s1_type;

   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        s1_ready, s2_ready;
   s1_type      s1_ff, s1_in;
   span_in_type s2_ff, s2_in;

   logic [2:0]         sector;
   chan_type           top;
   logic signed [13:0] inv_sat;
   logic [15:0]        hx;
   logic [15:0]        hx_wrap;
   logic [12:0]        x;

   logic signed [27:0] biased;
   logic signed [14:0] part;
   logic signed [15:0] factor;
   logic signed [24:0] scaled;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: sector decode, lightness product, hue distance
   always_comb begin
      sector  = sector_of(in_data.hue[14:12]);
      top     = chan_type'(sector[2:1]);
      inv_sat = $signed(14'(FIXED_ONE) - {1'b0, in_data.saturation});
      hx      = 16'(in_data.hue) + 16'(FIXED_ONE);
      hx_wrap = (hx >= 16'(HUE_TURN)) ? hx - 16'(HUE_TURN) : hx;
      x       = 13'(hx_wrap - {1'b0, top, 13'b0});

      s1_in.top = top;
      if (sector[0]) begin
         s1_in.mid = next_chan(top);
         s1_in.lo  = next_chan(next_chan(top));
      end else begin
         s1_in.lo  = next_chan(top);
         s1_in.mid = next_chan(next_chan(top));
      end
      s1_in.low   = in_data.lightness <= 13'(FIXED_HALF);
      s1_in.lprod = 28'($signed({1'b0, in_data.lightness}) * inv_sat);
      s1_in.sat   = in_data.saturation;
      s1_in.k     = in_data.scale;
      s1_in.twice = 22'({in_data.lightness, 1'b0}) * 22'(in_data.scale);
      s1_in.w     = (x >= 13'(FIXED_ONE)) ? x - 13'(FIXED_ONE) : 13'(FIXED_ONE) - x;
   end

   // stage 2: divide toward zero, then scale by brightness
   always_comb begin
      biased = s1_ff.lprod + (s1_ff.lprod[27] ? 28'(FIXED_ONE - 1) : 28'sd0);
      part   = biased[FIXED_SHIFT +: 15];
      factor = s1_ff.low ? {part[14], part} : {part[14], part} + $signed({3'b0, s1_ff.sat});
      scaled = factor * $signed({1'b0, s1_ff.k});

      s2_in.top   = s1_ff.top;
      s2_in.lo    = s1_ff.lo;
      s2_in.mid   = s1_ff.mid;
      s2_in.low   = s1_ff.low;
      s2_in.first = {{7{scaled[24]}}, scaled};
      s2_in.twice = s1_ff.twice;
      s2_in.w     = s1_ff.w;
   end

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

// File: rtl/hslrgb_span.sv
module hslrgb_span import hslrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  span_in_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output tail_type    out_data
);

   typedef struct packed {
      chan_type    top;
      chan_type    lo;
      chan_type    mid;
      logic [31:0] c_top;
      logic [31:0] c_lo;
      logic [12:0] w;
   } s3_type;

   logic     s3_valid_ff, s3_valid_in;
   logic     s4_valid_ff, s4_valid_in;
   logic     s3_ready, s4_ready;
   s3_type   s3_ff, s3_in;
   tail_type s4_ff, s4_in;

   logic [31:0] other;
   logic [31:0] diff;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   // stage 3: the other extreme is 2L*k minus the first one
   always_comb begin
      other       = {10'b0, in_data.twice} - in_data.first;
      s3_in.top   = in_data.top;
      s3_in.lo    = in_data.lo;
      s3_in.mid   = in_data.mid;
      s3_in.c_top = in_data.low ? other : in_data.first;
      s3_in.c_lo  = in_data.low ? in_data.first : other;
      s3_in.w     = in_data.w;
   end

   // stage 4: span times hue distance, modulo 2^32
   always_comb begin
      diff        = s3_ff.c_top - s3_ff.c_lo;
      s4_in.top   = s3_ff.top;
      s4_in.lo    = s3_ff.lo;
      s4_in.mid   = s3_ff.mid;
      s4_in.c_top = s3_ff.c_top;
      s4_in.c_lo  = s3_ff.c_lo;
      s4_in.prod  = 32'(diff * 32'(s3_ff.w));
   end

   assign s3_valid_in = s3_ready ? in_valid : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_ff <= s3_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

// File: rtl/hslrgb_out.sv
module hslrgb_out import hslrgb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  tail_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   logic    s5_valid_ff, s5_valid_in;
   rsp_type s5_ff, s5_in;

   logic [31:0] c_mid;
   logic [31:0] c_red, c_green, c_blue;

   function automatic logic [31:0] pick(input chan_type ch, input tail_type t,
                                        input logic [31:0] m);
      logic [31:0] v;
      if (ch == t.top) begin
         v = t.c_top;
      end else if (ch == t.lo) begin
         v = t.c_lo;
      end else begin
         v = m;
      end
      return v;
   endfunction

   function automatic logic [7:0] round_clamp(input logic [31:0] c);
      logic [31:0] s;
      logic [19:0] q;
      s = c + 32'(FIXED_HALF);
      q = s[31:FIXED_SHIFT];
      return (q < 20'(CLAMP_LIMIT)) ? q[7:0] : 8'(CLAMP_MAX);
   endfunction

   assign in_ready = !s5_valid_ff || out_ready;

   always_comb begin
      c_mid       = {12'b0, in_data.prod[31:FIXED_SHIFT]} + in_data.c_lo;
      c_red       = pick(CH_RED, in_data, c_mid);
      c_green     = pick(CH_GREEN, in_data, c_mid);
      c_blue      = pick(CH_BLUE, in_data, c_mid);
      s5_in.red   = round_clamp(c_red);
      s5_in.green = round_clamp(c_green);
      s5_in.blue  = round_clamp(c_blue);
   end

   assign s5_valid_in = in_ready ? in_valid : s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_ff;

endmodule

// File: rtl/hsl_to_rgb_fixed_point.sv
// HSL to RGB pixel converter, fixed point (4096 means one).
// Request channel: req_data carries hue, lightness, saturation and scale; a
// request is taken at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_data carries red, green and blue; a response is taken
// at an edge with rsp_valid high and rsp_stall low.
// Five register stages: sector decode and lightness product, divide and
// scale multiply, extreme channels, interpolation multiply, round and clamp.
// A taken request moves through the stages in the order listed and is offered
// on rsp_data from the round and clamp register.
// Throughput is one pixel per clock while rsp_stall is low; every stage holds
// one pixel and moves forward whenever the stage after it is empty or moving.
// When the receiver stalls, stages fill from the output backward and
// req_stall rises only once all five hold a pixel; nothing is dropped or
// sent twice. Pixels are independent, no state carries between them.
// Reset (synchronous) empties the pipeline; the first request may be sent
// in the cycle after reset falls.
module hsl_to_rgb_fixed_point import hslrgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        front_ready;
   logic        front_valid, span_ready;
   span_in_type front_data;
   logic        span_valid, out_ready;
   tail_type    span_data;
   logic        req_take;

   assign req_stall = !front_ready;
   assign req_take  = req_valid && front_ready;

   hslrgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (span_ready),
      .out_data  (front_data)
   );

   hslrgb_span u_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (span_ready),
      .in_data   (front_data),
      .out_valid (span_valid),
      .out_ready (out_ready),
      .out_data  (span_data)
   );

   hslrgb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (span_valid),
      .in_ready  (out_ready),
      .in_data   (span_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // backpressure can only start from a held response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled response");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_take ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("response missing after unstalled pipeline");

   // zero saturation within range gives a gray pixel
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.saturation == 13'd0 && req_data.lightness <= 13'(FIXED_ONE))
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> (rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue))
      else $error("gray input produced unequal channels");
`endif

endmodule
